// ===== rtl/skt_pkg.sv =====
// skt_pkg: shared constants, codes and controller/datapath interface types
// for the sorted key table; no dependencies
`default_nettype none

package skt_pkg;

    // field widths fixed by the item format
    localparam int KEY_W       = 15;
    localparam int DATA_W      = 32;
    localparam int OP_W        = 2;
    localparam int ST_W        = 3;
    localparam int POS_W       = 7;
    localparam int CFG_W       = 7;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    // configuration port
    localparam int APB_W  = 32;
    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-3:0] REG_PRESET = 1'b0;

    // parameter defaults
    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_VALUE_BITS = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // result status codes
    localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [ST_W-1:0] ST_FILLED    = 3'd1;
    localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
    localparam logic [ST_W-1:0] ST_FOUND     = 3'd4;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd5;
    localparam logic [ST_W-1:0] ST_CLEARED   = 3'd6;

    // controller to datapath commands
    typedef struct packed {
        logic            load;
        logic            srch_init;
        logic            rd_mid;
        logic            cmp;
        logic            shift_init;
        logic            rd_shift;
        logic            wr_shift;
        logic            wr_entry;
        logic            inc_used;
        logic            clr_init;
        logic            clr_wr;
        logic            res_load;
        logic [ST_W-1:0] res_status;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            srch_done;
        logic            hit;
        logic            unfilled;
        logic            full;
        logic            shift_done;
        logic            clr_done;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/skt_ctrl.sv =====
// skt_ctrl: sequencer for search, insert shift, clear sweep and result hand-off
// depends on skt_pkg
`default_nettype none

module skt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    input  wire skt_pkg::t_sts i_sts,
    output skt_pkg::t_cmd      o_cmd
);
    import skt_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_SRD  = 4'd2;
    localparam logic [3:0] S_SCMP = 4'd3;
    localparam logic [3:0] S_DEC  = 4'd4;
    localparam logic [3:0] S_SHRD = 4'd5;
    localparam logic [3:0] S_SHWR = 4'd6;
    localparam logic [3:0] S_CLR  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    logic [3:0]      r_state, n_state;
    logic [ST_W-1:0] r_code, n_code;
    logic            r_ovalid, n_ovalid;
    logic            w_out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign w_out_free    = !r_ovalid || m_axis_tready;

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_code   = r_code;
        n_ovalid = r_ovalid && !m_axis_tready;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.op == OP_ADD || i_sts.op == OP_LOOKUP) begin
                    o_cmd.srch_init = 1'b1;
                    n_state         = S_SRD;
                end else if (i_sts.op == OP_CLEAR) begin
                    o_cmd.clr_init = 1'b1;
                    n_state        = S_CLR;
                end else begin
                    n_code  = ST_NOT_FOUND;
                    n_state = S_FIN;
                end
            end
            S_SRD: begin
                if (i_sts.srch_done) begin
                    n_state = S_DEC;
                end else begin
                    o_cmd.rd_mid = 1'b1;
                    n_state      = S_SCMP;
                end
            end
            S_SCMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_SRD;
            end
            S_DEC: begin
                n_state = S_FIN;
                if (i_sts.op == OP_LOOKUP) begin
                    n_code = i_sts.hit ? ST_FOUND : ST_NOT_FOUND;
                end else if (i_sts.hit) begin
                    if (i_sts.unfilled) begin
                        o_cmd.wr_entry = 1'b1;
                        n_code         = ST_FILLED;
                    end else begin
                        n_code = ST_DUPLICATE;
                    end
                end else if (i_sts.full) begin
                    n_code = ST_FULL;
                end else begin
                    o_cmd.shift_init = 1'b1;
                    n_state          = S_SHRD;
                end
            end
            S_SHRD: begin
                if (i_sts.shift_done) begin
                    o_cmd.wr_entry = 1'b1;
                    o_cmd.inc_used = 1'b1;
                    n_code         = ST_INSERTED;
                    n_state        = S_FIN;
                end else begin
                    o_cmd.rd_shift = 1'b1;
                    n_state        = S_SHWR;
                end
            end
            S_SHWR: begin
                o_cmd.wr_shift = 1'b1;
                n_state        = S_SHRD;
            end
            S_CLR: begin
                if (i_sts.clr_done) begin
                    n_code  = ST_CLEARED;
                    n_state = S_FIN;
                end else begin
                    o_cmd.clr_wr = 1'b1;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_cmd.res_status = r_code;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_code   <= ST_NOT_FOUND;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_code   <= n_code;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/skt_datapath.sv =====
// skt_datapath: entry memory, search bounds, shift and clear pointers, result register
// depends on skt_pkg
`default_nettype none

module skt_datapath #(
    parameter int CAPACITY   = skt_pkg::DEF_CAPACITY,
    parameter int VALUE_BITS = skt_pkg::DEF_VALUE_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire skt_pkg::t_cmd               i_cmd,
    input  wire logic [skt_pkg::CFG_W-1:0]   i_preset,
    input  wire logic [skt_pkg::OP_W-1:0]    i_op,
    input  wire logic [skt_pkg::KEY_W-1:0]   i_key,
    input  wire logic [skt_pkg::DATA_W-1:0]  i_value,
    output skt_pkg::t_sts                    o_sts,
    output logic [skt_pkg::ST_W-1:0]         o_status,
    output logic [skt_pkg::DATA_W-1:0]       o_found_value,
    output logic [skt_pkg::POS_W-1:0]        o_position,
    output logic [skt_pkg::POS_W-1:0]        o_entry_count
);
    import skt_pkg::*;

    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int STORE_BITS = (VALUE_BITS < DATA_W) ? VALUE_BITS : DATA_W;
    localparam int ENT_W      = KEY_W + STORE_BITS;

    // entry memory: key in the upper bits, value below; zero value means unfilled
    logic [ENT_W-1:0] mem [CAPACITY];
    logic [ENT_W-1:0] r_rd;

    logic [OP_W-1:0]       r_op;
    logic [KEY_W-1:0]      r_key;
    logic [STORE_BITS-1:0] r_val;
    logic [CNT_W-1:0]      r_lo, r_hi, r_mid, r_ptr, r_n, r_used;
    logic                  r_hit;

    logic [ST_W-1:0]   r_res_status;
    logic [DATA_W-1:0] r_res_found;
    logic [POS_W-1:0]  r_res_pos, r_res_count;

    logic [CNT_W:0]        w_sum;
    logic [CNT_W-1:0]      w_mid, w_ptr_m1, w_pos, w_n;
    logic [KEY_W-1:0]      w_rd_key;
    logic [STORE_BITS-1:0] w_rd_val;
    logic                  w_we, w_re;
    logic [IDX_W-1:0]      w_waddr, w_raddr;
    logic [ENT_W-1:0]      w_wdata;

    assign w_sum    = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid    = w_sum[CNT_W:1];
    assign w_ptr_m1 = r_ptr - CNT_W'(1);
    assign w_pos    = r_hit ? r_mid : r_lo;
    assign w_rd_key = r_rd[ENT_W-1 -: KEY_W];
    assign w_rd_val = r_rd[STORE_BITS-1:0];
    assign w_n      = (32'(i_preset) > 32'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(i_preset);

    // memory port selection
    assign w_re    = i_cmd.rd_mid || i_cmd.rd_shift;
    assign w_raddr = i_cmd.rd_mid ? w_mid[IDX_W-1:0] : w_ptr_m1[IDX_W-1:0];
    assign w_we    = i_cmd.wr_shift || i_cmd.wr_entry || i_cmd.clr_wr;
    assign w_waddr = i_cmd.wr_entry ? w_pos[IDX_W-1:0] : r_ptr[IDX_W-1:0];

    always_comb begin
        if (i_cmd.wr_shift) begin
            w_wdata = r_rd;
        end else if (i_cmd.wr_entry) begin
            w_wdata = {r_key, r_val};
        end else begin
            w_wdata = {KEY_W'(r_ptr), STORE_BITS'(0)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= mem[w_raddr];
        end
    end

    // item capture, search bounds and pointers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_key <= i_key;
            r_val <= i_value[STORE_BITS-1:0];
        end
        if (i_cmd.srch_init) begin
            r_lo  <= '0;
            r_hi  <= r_used;
            r_hit <= 1'b0;
        end
        if (i_cmd.rd_mid) begin
            r_mid <= w_mid;
        end
        if (i_cmd.cmp) begin
            if (w_rd_key > r_key) begin
                r_hi <= r_mid;
            end else if (w_rd_key < r_key) begin
                r_lo <= r_mid + CNT_W'(1);
            end else begin
                r_hit <= 1'b1;
            end
        end
        if (i_cmd.shift_init) begin
            r_ptr <= r_used;
        end else if (i_cmd.wr_shift) begin
            r_ptr <= w_ptr_m1;
        end else if (i_cmd.clr_init) begin
            r_ptr <= '0;
            r_n   <= w_n;
        end else if (i_cmd.clr_wr) begin
            r_ptr <= r_ptr + CNT_W'(1);
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.clr_init) begin
            r_used <= w_n;
        end else if (i_cmd.inc_used) begin
            r_used <= r_used + CNT_W'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            r_res_found  <= (i_cmd.res_status == ST_FOUND) ? DATA_W'(w_rd_val) : '0;
            r_res_pos    <= (r_op == OP_ADD || r_op == OP_LOOKUP) ? POS_W'(w_pos) : '0;
            r_res_count  <= POS_W'(r_used);
        end
    end

    assign o_status      = r_res_status;
    assign o_found_value = r_res_found;
    assign o_position    = r_res_pos;
    assign o_entry_count = r_res_count;

    // status back to the controller
    assign o_sts.op         = r_op;
    assign o_sts.srch_done  = r_hit || (r_lo >= r_hi);
    assign o_sts.hit        = r_hit;
    assign o_sts.unfilled   = (w_rd_val == '0);
    assign o_sts.full       = (r_used >= CNT_W'(CAPACITY));
    assign o_sts.shift_done = (r_ptr == w_pos);
    assign o_sts.clr_done   = (r_ptr >= r_n);

endmodule

`default_nettype wire

// ===== rtl/sorted_key_table_top.sv =====
// sorted_key_table_top: top level with stream channels and the register port
// depends on skt_pkg, skt_ctrl, skt_datapath
//
// Keeps up to CAPACITY entries (key, value) in ascending key order in one
// memory. Input items arrive on s_axis: tuser carries the operation (add,
// lookup, clear), tdata the key and value. Each item gives one result item
// on m_axis: tuser carries the status, tdata the found value, the sorted
// position and the entry count after the operation.
// One item is worked on at a time. A lookup or a fill runs a binary search
// of about log2(entries)+1 steps, each a read of the middle entry and a
// compare; an insert then moves each entry from the position upward by one,
// as each moved entry needs a read and then a write of the memory. A clear
// writes the preset keys one per cycle, min(preset_count, CAPACITY) keys in
// all. The next item is accepted in the cycle after the result is loaded.
// The register preset_count sits at byte address 0 of the register port.
// Reset empties the table and clears preset_count; no memory sweep follows.
// When the receiver stalls, the result waits in the output register and the
// next item is still accepted and worked on; it then waits until the
// output register is free.
`default_nettype none

module sorted_key_table_top #(
    parameter int CAPACITY   = skt_pkg::DEF_CAPACITY,
    parameter int VALUE_BITS = skt_pkg::DEF_VALUE_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // key [14:0], value [46:15], zero [47]
    input  wire logic [skt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // operation [1:0]
    input  wire logic [skt_pkg::OP_W-1:0]         s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // found_value [31:0], position [38:32], entry_count [45:39], zero [47:46]
    output logic [skt_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // status [2:0]
    output logic [skt_pkg::ST_W-1:0]              m_axis_tuser,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [skt_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [skt_pkg::APB_W-1:0]        pwdata,
    output logic [skt_pkg::APB_W-1:0]             prdata,
    output logic                                  pready
);
    import skt_pkg::*;

    logic [CFG_W-1:0]  r_preset;
    logic              w_reg_sel;
    t_cmd              w_cmd;
    t_sts              w_sts;
    logic [DATA_W-1:0] w_found;
    logic [POS_W-1:0]  w_pos, w_count;

    // register port
    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[ADDR_W-1:2] == REG_PRESET);
    assign prdata    = w_reg_sel ? APB_W'(r_preset) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preset <= '0;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_preset <= pwdata[CFG_W-1:0];
        end
    end

    skt_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd)
    );

    skt_datapath #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_preset      (r_preset),
        .i_op          (s_axis_tuser),
        .i_key         (s_axis_tdata[KEY_W-1:0]),
        .i_value       (s_axis_tdata[KEY_W +: DATA_W]),
        .o_sts         (w_sts),
        .o_status      (m_axis_tuser),
        .o_found_value (w_found),
        .o_position    (w_pos),
        .o_entry_count (w_count)
    );

    // result packing
    assign m_axis_tdata = {{(OUT_TDATA_W - DATA_W - 2*POS_W){1'b0}}, w_count, w_pos, w_found};

endmodule

`default_nettype wire

// ===== sim/tb_sorted_key_table_top.sv =====
// tb_sorted_key_table_top: self-checking testbench for the sorted key table,
// with a table predictor, a queued stream driver, a result monitor and register writes
// depends on skt_pkg and sorted_key_table_top
`timescale 1ns / 1ps

module tb_sorted_key_table_top;
    import skt_pkg::*;

    localparam int CAP = DEF_CAPACITY;
    // operation code 3 is not defined by the block and must leave the table alone
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
    } t_table_req;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [DATA_W-1:0] found_value;
        logic [POS_W-1:0]  position;
        logic [POS_W-1:0]  entry_count;
    } t_table_resp;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [OP_W-1:0]         s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic [ST_W-1:0]         m_axis_tuser;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [ADDR_W-1:0]       paddr = '0;
    logic [APB_W-1:0]        pwdata = '0;
    logic [APB_W-1:0]        prdata;
    logic                    pready;

    sorted_key_table_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // predicted table contents
    logic [KEY_W-1:0]  tbl_keys   [CAP];
    logic [DATA_W-1:0] tbl_values [CAP];
    bit                tbl_filled [CAP];
    int unsigned       tbl_used = 0;
    int unsigned       tbl_preset = 0;

    t_table_req  pending_reqs [$];
    t_table_resp table_expect [$];
    int unsigned mismatch_count = 0;
    bit          idle_on = 1'b1;
    bit          src_taken = 1'b0;
    int unsigned src_gap = 0;
    int unsigned sink_gap = 0;
    int unsigned sink_hold_req = 0;
    int unsigned sink_hold_left = 0;

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("FAIL sorted_key_table_top");
        $finish;
    end

    // apply one operation to the predicted table and return the expected result
    function automatic t_table_resp apply_table_op(t_table_req req);
        t_table_resp r;
        int unsigned lo, hi, mid, slot, i;
        bit hit;
        r.status = ST_NOT_FOUND;
        r.found_value = '0;
        slot = 0;
        hit = 1'b0;
        // binary search, slot is the match or the insertion point
        if (req.op == OP_ADD || req.op == OP_LOOKUP) begin
            lo = 0;
            hi = tbl_used;
            while (lo < hi && !hit) begin
                mid = (lo + hi) / 2;
                if (tbl_keys[mid] > req.key) begin
                    hi = mid;
                end else if (tbl_keys[mid] < req.key) begin
                    lo = mid + 1;
                end else begin
                    hit = 1'b1;
                    slot = mid;
                end
            end
            if (!hit) slot = lo;
        end
        case (req.op)
            OP_ADD: begin
                if (!hit) begin
                    if (tbl_used >= CAP) begin
                        r.status = ST_FULL;
                    end else begin
                        for (i = tbl_used; i > slot; i--) begin
                            tbl_keys[i]   = tbl_keys[i-1];
                            tbl_values[i] = tbl_values[i-1];
                            tbl_filled[i] = tbl_filled[i-1];
                        end
                        tbl_keys[slot]   = req.key;
                        tbl_values[slot] = req.value;
                        tbl_filled[slot] = (req.value != '0);
                        tbl_used++;
                        r.status = ST_INSERTED;
                    end
                end else if (!tbl_filled[slot]) begin
                    tbl_values[slot] = req.value;
                    tbl_filled[slot] = (req.value != '0);
                    r.status = ST_FILLED;
                end else begin
                    r.status = ST_DUPLICATE;
                end
            end
            OP_LOOKUP: begin
                if (hit) begin
                    r.status = ST_FOUND;
                    r.found_value = tbl_filled[slot] ? tbl_values[slot] : '0;
                end
            end
            OP_CLEAR: begin
                // a preset above capacity saturates
                tbl_used = (tbl_preset > CAP) ? CAP : tbl_preset;
                for (i = 0; i < CAP; i++) begin
                    if (i < tbl_used) begin
                        tbl_keys[i]   = KEY_W'(i);
                        tbl_values[i] = '0;
                    end
                    tbl_filled[i] = 1'b0;
                end
                r.status = ST_CLEARED;
            end
            default: ;
        endcase
        r.position = POS_W'(slot);
        r.entry_count = POS_W'(tbl_used);
        return r;
    endfunction

    // random item with weighted operation, key and value choices
    function automatic t_table_req random_table_req(int unsigned clear_pct,
                                                    int unsigned add_pct);
        t_table_req req;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < clear_pct) req.op = OP_CLEAR;
        else if (pick < clear_pct + 3) req.op = OP_UNUSED;
        else if (pick < clear_pct + 3 + add_pct) req.op = OP_ADD;
        else req.op = OP_LOOKUP;
        // mostly keys near the preset range so hits, fills and duplicates occur
        pick = $urandom_range(0, 99);
        if (pick < 60) req.key = KEY_W'($urandom_range(0, 80));
        else if (pick < 72) req.key = KEY_W'($urandom_range(32760, 32767));
        else req.key = KEY_W'($urandom_range(0, 32767));
        pick = $urandom_range(0, 99);
        if (pick < 10) req.value = '0;
        else if (pick < 15) req.value = '1;
        else req.value = $urandom;
        return req;
    endfunction

    task automatic queue_req(input logic [OP_W-1:0] op, input int unsigned key,
                             input logic [DATA_W-1:0] value);
        t_table_req req;
        req.op = op;
        req.key = KEY_W'(key);
        req.value = value;
        pending_reqs = {pending_reqs, req};
    endtask

    // sender pause: wait until every queued item has been answered
    task automatic wait_table_idle();
        @(posedge i_clk);
        while (pending_reqs.size() != 0 || s_axis_tvalid || table_expect.size() != 0)
            @(posedge i_clk);
    endtask

    // register write of preset_count followed by a read-back
    task automatic write_preset(input logic [CFG_W-1:0] count);
        logic [APB_W-1:0] rd;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_PRESET, 2'b00};
        pwdata <= APB_W'(count);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tbl_preset = count;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd !== APB_W'(count)) begin
            if (mismatch_count < 10)
                $display("mismatch: preset_count read back %0d, expected %0d", rd, count);
            mismatch_count++;
        end
    endtask

    // driver: present queued items, random gaps only between items
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || src_taken) begin
            src_taken = 1'b0;
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin : drive_item
                t_table_req req;
                req = pending_reqs.pop_front();
                s_axis_tdata <= {1'b0, req.value, req.key};
                s_axis_tuser <= req.op;
                s_axis_tvalid <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 18);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready: long hold when requested, else random stall bursts
    always @(negedge i_clk) begin
        if (sink_hold_req > 0) begin
            sink_hold_left = sink_hold_req;
            sink_hold_req = 0;
        end
        if (sink_hold_left > 0) begin
            sink_hold_left--;
            m_axis_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 18);
        end
    end

    // monitor: predict on accepted input items, check accepted result items
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin : take_item
            t_table_req req;
            req.op = s_axis_tuser;
            req.key = s_axis_tdata[14:0];
            req.value = s_axis_tdata[46:15];
            table_expect = {table_expect, apply_table_op(req)};
            src_taken = 1'b1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin : check_item
            t_table_resp got, want;
            got.status = m_axis_tuser;
            got.found_value = m_axis_tdata[31:0];
            got.position = m_axis_tdata[38:32];
            got.entry_count = m_axis_tdata[45:39];
            if (table_expect.size() == 0) begin
                if (mismatch_count < 10)
                    $display("mismatch: unexpected result status %0d value %h pos %0d count %0d",
                             got.status, got.found_value, got.position, got.entry_count);
                mismatch_count++;
            end else begin
                want = table_expect.pop_front();
                if (got !== want) begin
                    if (mismatch_count < 10)
                        $display({"mismatch at %0t: status %0d/%0d value %h/%h ",
                                  "pos %0d/%0d count %0d/%0d (actual/expected)"}, $realtime,
                                 got.status, want.status, got.found_value, want.found_value,
                                 got.position, want.position, got.entry_count, want.entry_count);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus: reset, directed cases, then random phases over several presets
    initial begin
        int unsigned phase_preset [6];
        int unsigned phase_clear [6];
        int unsigned phase_add [6];
        int unsigned phase_len [6];
        int unsigned p, n;
        phase_preset = '{0, 127, 1, 37, 0, 64};
        phase_clear  = '{0, 3, 8, 4, 5, 3};
        phase_add    = '{70, 55, 50, 55, 50, 50};
        phase_len    = '{140, 130, 130, 130, 130, 130};
        phase_preset[4] = $urandom_range(0, 64);
        for (p = 0; p < CAP; p++) begin
            tbl_keys[p] = '0;
            tbl_values[p] = '0;
            tbl_filled[p] = 1'b0;
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, unused operation, extremes of key and value
        queue_req(OP_LOOKUP, 0, 32'h0000_0001);
        queue_req(OP_UNUSED, 32767, 32'hFFFF_FFFF);
        queue_req(OP_ADD, 32767, 32'hFFFF_FFFF);
        queue_req(OP_ADD, 0, 32'h0000_0001);
        // add with zero value stays unfilled, then gets filled, then duplicates
        queue_req(OP_ADD, 16384, 32'h0000_0000);
        queue_req(OP_LOOKUP, 16384, 32'h0);
        queue_req(OP_ADD, 16384, 32'hA5A5_A5A5);
        queue_req(OP_ADD, 16384, 32'h0000_0005);
        queue_req(OP_LOOKUP, 16384, 32'h0);
        queue_req(OP_ADD, 21845, 32'h5555_5555);
        queue_req(OP_LOOKUP, 32767, 32'h0);
        queue_req(OP_LOOKUP, 1, 32'h0);
        queue_req(OP_ADD, 0, 32'h0000_0007);
        queue_req(OP_CLEAR, 0, 32'h0);
        wait_table_idle();

        // full preset table: add of absent key is refused, present keys fill
        write_preset(7'd64);
        queue_req(OP_CLEAR, 10922, 32'h0);
        queue_req(OP_ADD, 100, 32'h1234_5678);
        queue_req(OP_ADD, 63, 32'h8000_0000);
        queue_req(OP_LOOKUP, 63, 32'h0);
        queue_req(OP_LOOKUP, 10, 32'h0);
        queue_req(OP_ADD, 5, 32'h0);
        queue_req(OP_ADD, 5, 32'h0000_0009);
        wait_table_idle();

        // preset above capacity saturates
        write_preset(7'd127);
        queue_req(OP_CLEAR, 0, 32'h0);
        queue_req(OP_LOOKUP, 63, 32'h0);
        wait_table_idle();

        for (p = 0; p < 6; p++) begin
            write_preset(CFG_W'(phase_preset[p]));
            if (p == 5) idle_on = 1'b0;
            queue_req(OP_CLEAR, $urandom_range(0, 32767), $urandom);
            for (n = 1; n < phase_len[p]; n++)
                pending_reqs = {pending_reqs, random_table_req(phase_clear[p], phase_add[p])};
            // receiver holds off long enough for the block to back up its input
            if (p == 3) sink_hold_req = 600;
            wait_table_idle();
        end

        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0 && table_expect.size() == 0) begin
            $display("PASS sorted_key_table_top");
        end else begin
            $display("FAIL sorted_key_table_top");
        end
        $finish;
    end

endmodule
